// ===== rtl/core/catmull_rom_spline_point_top_macros.svh =====
// Assertion macros for the control block of the spline point evaluator.
`ifndef CATMULL_ROM_SPLINE_POINT_TOP_MACROS_SVH
`define CATMULL_ROM_SPLINE_POINT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define CRSP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define CRSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CRSP_ASSERT_SAME(lbl, ante, cons, msg)
`define CRSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/crsp_pkg.sv =====
// Shared types and constants for the spline point evaluator.
package crsp_pkg;

    localparam int COORD_W        = 32;
    localparam int INDEX_W        = 6;
    localparam int COUNT_W        = 7;
    localparam int FRAC_W         = 16;
    localparam int T_W            = FRAC_W + 1;
    localparam int LANES          = 4;
    localparam int NUM_BANKS      = 4;
    localparam int NUM_STAGES     = 7;
    localparam int MAX_POINTS_DEF = 64;

    localparam logic [T_W-1:0]     T_ONE       = T_W'(1) << FRAC_W;
    localparam logic [COUNT_W-1:0] MIN_POINTS  = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    // One control point: lane 0 is x, then y, z and w.
    typedef logic [LANES-1:0][COORD_W-1:0] t_point;

    typedef struct packed {
        t_op                        operation;
        logic [INDEX_W-1:0]         point_index;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic signed [COORD_W-1:0]  coord_w;
        logic [T_W-1:0]             param_t;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  pos_z;
        logic signed [COORD_W-1:0]  pos_w;
        logic                       clamped;
    } t_out_word;

    // Pipeline control from the sequencer to the banks and lanes.
    typedef struct packed {
        logic [NUM_STAGES:0] load;
        logic [1:0]          rot;
        logic [T_W-1:0]      t1;
        logic [T_W-1:0]      t3;
        logic [T_W-1:0]      t5;
        logic                use_pt;
    } t_pipe_ctl;

endpackage

// ===== rtl/core/crsp_bank.sv =====
// One interleaved bank of the control point table with a registered read port.
module crsp_bank #(
    parameter int DEPTH = 16,
    parameter int RW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [RW-1:0]    i_row,
    input  crsp_pkg::t_point i_wdata,
    output crsp_pkg::t_point o_rdata
);
    import crsp_pkg::*;

    t_point r_mem [DEPTH];
    t_point r_rdata;

    // Write and read share the row address; an item does one or the other.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_row] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_row];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/crsp_lane.sv =====
// One component lane of the Catmull-Rom evaluator: a six-stage Horner pipeline.
module crsp_lane (
    input  logic                                                 i_clk,
    input  logic [crsp_pkg::NUM_BANKS-1:0][crsp_pkg::COORD_W-1:0] i_bank,
    input  crsp_pkg::t_pipe_ctl                                  i_ctl,
    output logic signed [crsp_pkg::COORD_W-1:0]                  o_pos
);
    import crsp_pkg::*;

    localparam int WA = COORD_W + 1;      // p2 - p0
    localparam int WB = COORD_W + 4;      // b and c coefficients
    localparam int WH = COORD_W + 5;      // Horner partial sums
    localparam int PW = WH + FRAC_W;      // product of a partial sum and t
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);

    localparam logic signed [WH-1:0] POS_MAX =
        {{(WH-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [WH-1:0] POS_MIN =
        {{(WH-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    // Multiply by t in Q1.16; t equal to one is a plain shift.
    function automatic logic signed [PW-1:0] mul_t(input logic signed [WH-1:0] x,
                                                   input logic [T_W-1:0] t);
        logic signed [PW:0] full;
        if (t[T_W-1]) begin
            full = (PW+1)'(x) <<< FRAC_W;
        end else begin
            full = (PW+1)'(x) * (PW+1)'($signed({1'b0, t[T_W-2:0]}));
        end
        return full[PW-1:0];
    endfunction

    // Drop the fraction, rounding half towards plus infinity.
    function automatic logic signed [WH-1:0] rnd(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p + PW'(ROUND_HALF);
        return s[PW-1:FRAC_W];
    endfunction

    logic signed [COORD_W-1:0] p0, p1, p2, p3;
    logic signed [WB-1:0]      p0e, p1e, p2e, p3e;
    logic signed [WH-1:0]      h0, hr, sat;

    logic signed [WA-1:0]      r1_a, r2_a, r3_a, r4_a;
    logic signed [WB-1:0]      r1_b, r2_b, r1_c;
    logic signed [WA-1:0]      r1_p1x2, r2_p1x2, r3_p1x2, r4_p1x2, r5_p1x2, r6_p1x2;
    logic signed [COORD_W-1:0] r1_p0, r2_p0, r3_p0, r4_p0, r5_p0, r6_p0;
    logic signed [PW-1:0]      r2_prod, r4_prod, r6_prod;
    logic signed [WH-1:0]      r3_h2, r5_h1;

    // Put the four banks back in segment order.
    always_comb begin
        p0  = i_bank[i_ctl.rot];
        p1  = i_bank[2'(i_ctl.rot + 2'd1)];
        p2  = i_bank[2'(i_ctl.rot + 2'd2)];
        p3  = i_bank[2'(i_ctl.rot + 2'd3)];
        p0e = WB'(p0);
        p1e = WB'(p1);
        p2e = WB'(p2);
        p3e = WB'(p3);
    end

    // Stage 1 forms the coefficients; stages 2 to 6 alternate multiply and add.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            r1_a    <= WA'(p2) - WA'(p0);
            r1_b    <= (p0e <<< 1) - ((p1e <<< 2) + p1e) + (p2e <<< 2) - p3e;
            r1_c    <= ((p1e <<< 1) + p1e) - ((p2e <<< 1) + p2e) + p3e - p0e;
            r1_p1x2 <= WA'(p1) <<< 1;
            r1_p0   <= p0;
        end
        if (i_ctl.load[2]) begin
            r2_prod <= mul_t(WH'(r1_c), i_ctl.t1);
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_p1x2 <= r1_p1x2;
            r2_p0   <= r1_p0;
        end
        if (i_ctl.load[3]) begin
            r3_h2   <= WH'(r2_b) + rnd(r2_prod);
            r3_a    <= r2_a;
            r3_p1x2 <= r2_p1x2;
            r3_p0   <= r2_p0;
        end
        if (i_ctl.load[4]) begin
            r4_prod <= mul_t(r3_h2, i_ctl.t3);
            r4_a    <= r3_a;
            r4_p1x2 <= r3_p1x2;
            r4_p0   <= r3_p0;
        end
        if (i_ctl.load[5]) begin
            r5_h1   <= WH'(r4_a) + rnd(r4_prod);
            r5_p1x2 <= r4_p1x2;
            r5_p0   <= r4_p0;
        end
        if (i_ctl.load[6]) begin
            r6_prod <= mul_t(r5_h1, i_ctl.t5);
            r6_p1x2 <= r5_p1x2;
            r6_p0   <= r5_p0;
        end
    end

    // Last add, halve with rounding up, saturate, or pass the stored point.
    always_comb begin
        h0 = WH'(r6_p1x2) + rnd(r6_prod);
        hr = (h0 + WH'(1)) >>> 1;
        if (hr > POS_MAX) begin
            sat = POS_MAX;
        end else if (hr < POS_MIN) begin
            sat = POS_MIN;
        end else begin
            sat = hr;
        end
        o_pos = i_ctl.use_pt ? r6_p0 : sat[COORD_W-1:0];
    end

endmodule

// ===== rtl/core/crsp_ctrl.sv =====
// Admission, bank addressing and pipeline flow control of the spline evaluator.
`include "catmull_rom_spline_point_top_macros.svh"
module crsp_ctrl #(
    parameter int MAX_POINTS = crsp_pkg::MAX_POINTS_DEF,
    parameter int RW         = 4
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    input  crsp_pkg::t_in_word                          i_word,
    input  logic [crsp_pkg::COUNT_W-1:0]                i_count,
    input  logic                                        i_out_stall,
    output logic                                        o_in_stall,
    output logic [crsp_pkg::NUM_BANKS-1:0]              o_we,
    output logic [crsp_pkg::NUM_BANKS-1:0][RW-1:0]      o_row,
    output crsp_pkg::t_pipe_ctl                         o_ctl,
    output logic                                        o_out_valid
);
    import crsp_pkg::*;

    logic [NUM_STAGES-1:0] r_v, n_v;
    logic                  r_out_valid, n_out_valid;
    logic [NUM_STAGES:0]   free;
    logic [NUM_STAGES-1:0] move;
    logic [NUM_STAGES:0]   load;
    logic                  acc, is_write, in_range, use_pt;
    logic [COUNT_W-1:0]    n_lo, n_use, idx_ext, base;
    logic [COUNT_W:0]      addr;
    logic [RW-1:0]         wrow;
    logic [T_W-1:0]        t_clip;

    logic [1:0]            r_rot;
    logic [T_W-1:0]        r_t [NUM_STAGES-1];
    logic [NUM_STAGES-1:0] r_use;

    // Stage k moves on when the stage after it is empty or moving too.
    always_comb begin
        free[NUM_STAGES] = !r_out_valid || !i_out_stall;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            move[k] = r_v[k] && free[k+1];
            free[k] = !r_v[k] || move[k];
        end
        acc        = i_in_valid && free[0];
        o_in_stall = !free[0];
        is_write   = (i_word.operation == OP_WRITE);
        load[0]    = acc && !is_write;
        for (int k = 0; k < NUM_STAGES; k++) begin
            load[k+1] = move[k];
            n_v[k]    = load[k] || (r_v[k] && !move[k]);
        end
        n_out_valid = load[NUM_STAGES] || (r_out_valid && i_out_stall);
    end

    // Effective point count, segment base and the clamped-index cases.
    always_comb begin
        n_lo    = (i_count < MIN_POINTS) ? MIN_POINTS : i_count;
        n_use   = (32'(n_lo) > MAX_POINTS) ? COUNT_W'(MAX_POINTS) : n_lo;
        idx_ext = COUNT_W'(i_word.point_index);
        if (i_word.point_index == '0) begin
            base   = COUNT_W'(1);
            use_pt = 1'b1;
        end else if (idx_ext > n_use - COUNT_W'(3)) begin
            base   = n_use - COUNT_W'(2);
            use_pt = 1'b1;
        end else begin
            base   = idx_ext - COUNT_W'(1);
            use_pt = 1'b0;
        end
        t_clip   = (i_word.param_t > T_ONE) ? T_ONE : i_word.param_t;
        in_range = (32'(i_word.point_index) < MAX_POINTS);
        wrow     = RW'(i_word.point_index >> 2);
    end

    // Consecutive entries fall in distinct banks; each bank reads its own row.
    always_comb begin
        addr = '0;
        for (int j = 0; j < NUM_BANKS; j++) begin
            addr    = {1'b0, base} + (COUNT_W+1)'(2'(2'(j) - base[1:0]));
            o_we[j] = acc && is_write && in_range && (i_word.point_index[1:0] == 2'(j));
            o_row[j] = is_write ? wrow : RW'(addr >> 2);
        end
    end

    // Valid bits of the stages and the output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_v         <= n_v;
            r_out_valid <= n_out_valid;
        end
    end

    // Per-item side information that travels alongside the lanes.
    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_rot    <= base[1:0];
            r_t[0]   <= t_clip;
            r_use[0] <= use_pt;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (load[k]) begin
                r_use[k] <= r_use[k-1];
            end
        end
        for (int k = 1; k < NUM_STAGES - 1; k++) begin
            if (load[k]) begin
                r_t[k] <= r_t[k-1];
            end
        end
    end

    always_comb begin
        o_ctl.load   = load;
        o_ctl.rot    = r_rot;
        o_ctl.t1     = r_t[1];
        o_ctl.t3     = r_t[3];
        o_ctl.t5     = r_t[5];
        o_ctl.use_pt = r_use[NUM_STAGES-1];
    end

    assign o_out_valid = r_out_valid;

    // An evaluate word fills the first stage, a write word never does.
    `CRSP_ASSERT_NEXT(a_entry_kind, acc, r_v[0] == $past(i_word.operation == OP_EVAL), "stage 0 fill does not match the accepted word")
    // Words in flight change only by entries and deliveries.
    `CRSP_ASSERT_NEXT(a_no_loss, i_rst_n, ($countones({r_v, r_out_valid}) == $past($countones({r_v, r_out_valid})) + int'($past(load[0])) - int'($past(r_out_valid && !i_out_stall))), "a word was lost or duplicated in the pipeline")
    // An empty first stage never stalls the input.
    `CRSP_ASSERT_SAME(a_empty_accepts, !r_v[0], !o_in_stall, "input stalled with an empty first stage")

endmodule

// ===== rtl/core/catmull_rom_spline_point_top.sv =====
// Top level of the uniform Catmull-Rom spline point evaluator.
//
// Usage: the input channel carries write words (store one four-component
// control point) and evaluate words (segment start index and t in Q1.16).
// Words move on i_in_valid/o_in_stall, results on o_out_valid/i_out_stall;
// a word passes at a clock edge where valid is high and stall is low.
// The point count register is written through i_cfg_valid/i_cfg_data
// (o_cfg_ready is always high); the user must write it only while the
// block is idle, which the block itself does not enforce. Throughput is
// one word per cycle while the receiver does not stall: the table sits
// in four interleaved banks, so the four points of a segment are read in
// a single access, and the four lanes each run a six-stage multiply/add
// pipeline. Writes give no result and take effect for the next word.
// Reset clears the pipeline valid bits and sets the point count to 4; the
// table is not cleared, so a point must be written before it is read.
// When the receiver stalls, words keep entering until the pipeline backs
// up to the input; then o_in_stall rises.
module catmull_rom_spline_point_top #(
    parameter int MAX_POINTS = crsp_pkg::MAX_POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    input  logic [crsp_pkg::COUNT_W-1:0] i_cfg_data,
    output logic                         o_cfg_ready,
    input  logic                         i_in_valid,
    input  crsp_pkg::t_in_word           i_in_word,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output crsp_pkg::t_out_word          o_out_word,
    input  logic                         i_out_stall
);
    import crsp_pkg::*;

    localparam int BANK_DEPTH = (MAX_POINTS + NUM_BANKS - 1) / NUM_BANKS;
    localparam int RW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic [COUNT_W-1:0]                     r_point_count;
    logic [NUM_BANKS-1:0]                   we;
    logic [NUM_BANKS-1:0][RW-1:0]           row;
    t_pipe_ctl                              ctl;
    t_point                                 wdata;
    t_point                                 rdata [NUM_BANKS];
    logic [NUM_BANKS-1:0][COORD_W-1:0]      lane_in [LANES];
    logic signed [COORD_W-1:0]              lane_pos [LANES];
    t_out_word                              n_out, r_out;

    // Point count register.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= COUNT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_point_count <= i_cfg_data;
        end
    end

    crsp_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .RW         (RW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_word      (i_in_word),
        .i_count     (r_point_count),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_we        (we),
        .o_row       (row),
        .o_ctl       (ctl),
        .o_out_valid (o_out_valid)
    );

    // Point to store, lane 0 first.
    always_comb begin
        wdata[0] = i_in_word.coord_x;
        wdata[1] = i_in_word.coord_y;
        wdata[2] = i_in_word.coord_z;
        wdata[3] = i_in_word.coord_w;
    end

    for (genvar j = 0; j < NUM_BANKS; j++) begin : g_bank
        crsp_bank #(
            .DEPTH (BANK_DEPTH),
            .RW    (RW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we[j]),
            .i_re    (ctl.load[0]),
            .i_row   (row[j]),
            .i_wdata (wdata),
            .o_rdata (rdata[j])
        );
    end

    // Each lane sees its own component from all four banks.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            for (int j = 0; j < NUM_BANKS; j++) begin
                lane_in[l][j] = rdata[j][l];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        crsp_lane u_lane (
            .i_clk  (i_clk),
            .i_bank (lane_in[l]),
            .i_ctl  (ctl),
            .o_pos  (lane_pos[l])
        );
    end

    // Merge the lane results into the output word register.
    always_comb begin
        n_out.pos_x   = lane_pos[0];
        n_out.pos_y   = lane_pos[1];
        n_out.pos_z   = lane_pos[2];
        n_out.pos_w   = lane_pos[3];
        n_out.clamped = ctl.use_pt;
    end

    always_ff @(posedge i_clk) begin
        if (ctl.load[NUM_STAGES]) begin
            r_out <= n_out;
        end
    end

    assign o_out_word = r_out;

endmodule
